// ===== rtl/core/speed_profile_time_interpolator_unit_assert.svh =====
// Assertion macros shared by the interpolator modules.
`ifndef SPEED_PROFILE_TIME_INTERPOLATOR_UNIT_ASSERT_SVH
`define SPEED_PROFILE_TIME_INTERPOLATOR_UNIT_ASSERT_SVH
// Implication checked on every rising clock edge outside reset.
`define SPTI_ASSERT_IMP(lbl, clk, rst_n, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define SPTI_ASSERT_NXT(lbl, clk, rst_n, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("assertion failed");
`endif

// ===== rtl/core/spti_pkg.sv =====
// Shared types and constants of the speed profile interpolator.
package spti_pkg;
  localparam int unsigned Depth = 64;
  localparam int unsigned IdxW = $clog2(Depth);
  localparam int unsigned CntW = IdxW + 1;
  localparam int unsigned ValW = 32;
  localparam int unsigned RatW = 30;

  localparam logic [1:0] CmdAppend = 2'd0;
  localparam logic [1:0] CmdClear = 2'd1;
  localparam logic [1:0] CmdEval = 2'd2;

  localparam logic [1:0] StOk = 2'd0;
  localparam logic [1:0] StFew = 2'd1;
  localparam logic [1:0] StSpan = 2'd2;
  localparam logic [1:0] StFull = 2'd3;

  typedef struct packed {
    logic [1:0] command;
    logic signed [ValW-1:0] point_pos;
    logic signed [ValW-1:0] point_time;
    logic signed [ValW-1:0] point_speed;
    logic signed [ValW-1:0] point_accel;
    logic signed [ValW-1:0] point_jerk;
  } req_t;

  typedef struct packed {
    logic [1:0] status;
    logic signed [ValW-1:0] out_pos;
    logic signed [ValW-1:0] out_time;
    logic signed [ValW-1:0] out_speed;
    logic signed [ValW-1:0] out_accel;
    logic signed [ValW-1:0] out_jerk;
    logic signed [ValW-1:0] span_time;
    logic [CntW-1:0] point_count;
  } rsp_t;

  // Classified job handed from the front end to the back end.
  typedef struct packed {
    logic eval;
    logic [1:0] status;
    logic [CntW-1:0] count;
    logic signed [ValW-1:0] query;
    logic signed [ValW-1:0] first_t;
    logic signed [ValW-1:0] last_t;
    logic signed [ValW-1:0] span;
  } job_t;
endpackage

// ===== rtl/core/speed_profile_time_interpolator_unit.sv =====
// One request at a time: the next is taken the cycle after the response leaves. Each
// search step of an evaluate passes SSrchRd, SSrchWt and SSrchCmp; the serial ratio
// divide and four multiply passes (SMul, SProd, SAcc) also set the evaluate time.
// Reset clears the point count and handshake state; table contents are kept.
// Top level of the speed profile time interpolator.
module speed_profile_time_interpolator_unit (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  spti_pkg::req_t in_data_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output spti_pkg::rsp_t out_data_o
);
  logic job_valid, job_stall, wr_en;
  spti_pkg::job_t job;
  logic [spti_pkg::IdxW-1:0] wr_addr, rd_addr;
  logic [5*spti_pkg::ValW-1:0] rd_data;

  spti_front u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .in_data_i,
    .job_valid_o(job_valid), .job_stall_i(job_stall), .job_o(job),
    .wr_en_o(wr_en), .wr_addr_o(wr_addr)
  );

  spti_ram #(.Width(5*spti_pkg::ValW), .Depth(spti_pkg::Depth)) u_table (
    .clk_i, .we_i(wr_en), .waddr_i(wr_addr),
    .wdata_i({in_data_i.point_pos, in_data_i.point_time, in_data_i.point_speed,
              in_data_i.point_accel, in_data_i.point_jerk}),
    .raddr_i(rd_addr), .rdata_o(rd_data)
  );

  spti_back u_back (
    .clk_i, .rst_ni, .job_valid_i(job_valid), .job_stall_o(job_stall), .job_i(job),
    .rd_addr_o(rd_addr), .rd_data_i(rd_data), .out_valid_o, .out_stall_i, .out_data_o
  );
endmodule

// ===== rtl/core/spti_ram.sv =====
// Generic single-port-write, one-read RAM with registered read data.
module spti_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end
endmodule

// ===== rtl/core/spti_front.sv =====
// Front end: accepts requests, appends points, tracks count and end times.
module spti_front (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  spti_pkg::req_t        in_data_i,
  output logic                  job_valid_o,
  input  logic                  job_stall_i,
  output spti_pkg::job_t        job_o,
  output logic                  wr_en_o,
  output logic [spti_pkg::IdxW-1:0] wr_addr_o
);
  `include "speed_profile_time_interpolator_unit_assert.svh"

  logic [spti_pkg::CntW-1:0] cnt_q, cnt_d;
  logic signed [spti_pkg::ValW-1:0] first_q, first_d, last_q, last_d;
  logic job_valid_q;
  spti_pkg::job_t job_q;
  logic acc;
  logic signed [spti_pkg::ValW:0] span_w;
  logic signed [spti_pkg::ValW-1:0] span_sat;
  spti_pkg::job_t job_d;
  logic full;

  // One job in flight at a time keeps table writes away from a running search.
  assign in_stall_o = job_valid_q || job_stall_i;
  assign acc = in_valid_i && !in_stall_o;
  assign full = (cnt_q == spti_pkg::CntW'(spti_pkg::Depth));
  assign wr_en_o = acc && (in_data_i.command == spti_pkg::CmdAppend) && !full;
  assign wr_addr_o = cnt_q[spti_pkg::IdxW-1:0];

  always_comb begin
    cnt_d = cnt_q;
    first_d = first_q;
    last_d = last_q;
    if (acc) begin
      if (wr_en_o) begin
        cnt_d = cnt_q + 1'b1;
        last_d = in_data_i.point_time;
        if (cnt_q == '0) begin
          first_d = in_data_i.point_time;
        end
      end else if (in_data_i.command == spti_pkg::CmdClear) begin
        cnt_d = '0;
      end
    end
    span_w = {last_d[spti_pkg::ValW-1], last_d} - {first_d[spti_pkg::ValW-1], first_d};
    if (span_w[spti_pkg::ValW] != span_w[spti_pkg::ValW-1]) begin
      span_sat = span_w[spti_pkg::ValW] ? {1'b1, {(spti_pkg::ValW-1){1'b0}}}
                                        : {1'b0, {(spti_pkg::ValW-1){1'b1}}};
    end else begin
      span_sat = span_w[spti_pkg::ValW-1:0];
    end
    job_d.eval = 1'b0;
    job_d.status = spti_pkg::StOk;
    job_d.count = cnt_d;
    job_d.query = in_data_i.point_time;
    job_d.first_t = first_q;
    job_d.last_t = last_q;
    job_d.span = (cnt_d == '0) ? '0 : span_sat;
    case (in_data_i.command)
      spti_pkg::CmdAppend: if (full) job_d.status = spti_pkg::StFull;
      spti_pkg::CmdEval: begin
        if (cnt_q < spti_pkg::CntW'(2)) begin
          job_d.status = spti_pkg::StFew;
        end else if (in_data_i.point_time < first_q || in_data_i.point_time > last_q) begin
          job_d.status = spti_pkg::StSpan;
        end else begin
          job_d.eval = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      job_valid_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      if (acc) begin
        job_valid_q <= 1'b1;
      end else if (!job_stall_i) begin
        job_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    first_q <= first_d;
    last_q <= last_d;
    if (acc) begin
      job_q <= job_d;
    end
  end

  assign job_valid_o = job_valid_q;
  assign job_o = job_q;

  `SPTI_ASSERT_IMP(a_cnt_max, clk_i, rst_ni, 1'b1, cnt_q <= spti_pkg::CntW'(spti_pkg::Depth))
  `SPTI_ASSERT_IMP(a_no_wr_busy, clk_i, rst_ni, job_valid_q, !wr_en_o)
  `SPTI_ASSERT_NXT(a_acc_job, clk_i, rst_ni, acc, job_valid_q)
endmodule

// ===== rtl/core/spti_back.sv =====
// Back end: binary search, ratio divide and per-quantity interpolation.
module spti_back (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      job_valid_i,
  output logic                      job_stall_o,
  input  spti_pkg::job_t            job_i,
  output logic [spti_pkg::IdxW-1:0] rd_addr_o,
  input  logic [5*spti_pkg::ValW-1:0] rd_data_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output spti_pkg::rsp_t            out_data_o
);
  `include "speed_profile_time_interpolator_unit_assert.svh"

  localparam int unsigned VW = spti_pkg::ValW;
  localparam int unsigned RW = spti_pkg::RatW;
  localparam int unsigned CW = spti_pkg::CntW;
  localparam int unsigned IW = spti_pkg::IdxW;
  localparam int unsigned DivCntW = $clog2(RW + 1);

  localparam logic [3:0] SIdle = 4'd0;
  localparam logic [3:0] SSrchRd = 4'd1;
  localparam logic [3:0] SSrchWt = 4'd2;
  localparam logic [3:0] SSrchCmp = 4'd3;
  localparam logic [3:0] SRdA = 4'd4;
  localparam logic [3:0] SRdB = 4'd5;
  localparam logic [3:0] SGetA = 4'd6;
  localparam logic [3:0] SGetB = 4'd7;
  localparam logic [3:0] SDiv = 4'd8;
  localparam logic [3:0] SMul = 4'd9;
  localparam logic [3:0] SAcc = 4'd10;
  localparam logic [3:0] SOut = 4'd11;
  localparam logic [3:0] SProd = 4'd12;

  logic [3:0] st_q, st_d;
  spti_pkg::job_t job_q;
  logic [CW-1:0] lo_q, lo_d, cnt_q, cnt_d, step_w, mid_w;
  logic [VW-1:0] pa_q [5];
  logic [VW-1:0] pb_q [5];
  logic [VW:0] dtot_q, rem_q;
  logic [RW:0] quo_q;
  logic [DivCntW-1:0] dstep_q;
  logic [2:0] qi_q;
  logic [VW:0] mag_q;
  logic neg_q;
  logic [VW+RW:0] mulr_q;
  spti_pkg::rsp_t res_q;
  logic res_valid_q;
  logic [IW-1:0] raddr;
  logic signed [VW:0] dx_w, dts_w;
  logic [VW:0] rem_sh;
  logic [VW:0] pr_w;
  logic signed [VW:0] val_w;
  logic signed [VW-1:0] t_mid;
  logic job_acc;

  assign job_stall_o = (st_q != SIdle) || res_valid_q;
  assign job_acc = (st_q == SIdle) && job_valid_i && !job_stall_o;
  assign step_w = cnt_q >> 1;
  assign mid_w = lo_q + step_w;
  assign t_mid = rd_data_i[4*VW-1:3*VW];
  assign rd_addr_o = raddr;

  always_comb begin
    raddr = mid_w[IW-1:0];
    if (st_q == SRdA) raddr = (lo_q == '0) ? '0 : lo_q[IW-1:0] - 1'b1;
    if (st_q == SRdB) raddr = (lo_q >= job_q.count) ? job_q.count[IW-1:0] - 1'b1
                                                     : lo_q[IW-1:0];
  end

  assign dx_w = $signed({pb_q[qi_q][VW-1], pb_q[qi_q]}) - $signed({pa_q[qi_q][VW-1], pa_q[qi_q]});
  assign dts_w = $signed({job_q.query[VW-1], job_q.query})
               - $signed({pa_q[1][VW-1], pa_q[1]});
  assign rem_sh = {rem_q[VW-1:0], 1'b0};
  assign pr_w = mulr_q[VW+RW:RW];
  assign val_w = neg_q ? $signed({pa_q[qi_q][VW-1], pa_q[qi_q]}) - $signed(pr_w)
                       : $signed({pa_q[qi_q][VW-1], pa_q[qi_q]}) + $signed(pr_w);

  always_comb begin
    st_d = st_q;
    lo_d = lo_q;
    cnt_d = cnt_q;
    unique case (st_q)
      SIdle: if (job_acc) begin
        st_d = job_i.eval ? SSrchRd : SOut;
        lo_d = '0;
        cnt_d = job_i.count;
      end
      SSrchRd: st_d = (cnt_q == '0) ? SRdA : SSrchWt;
      SSrchWt: st_d = SSrchCmp;
      SSrchCmp: begin
        if ($signed(t_mid) < job_q.query) begin
          lo_d = mid_w + 1'b1;
          cnt_d = cnt_q - step_w - 1'b1;
        end else begin
          cnt_d = step_w;
        end
        st_d = SSrchRd;
      end
      SRdA: st_d = SRdB;
      SRdB: st_d = SGetA;
      SGetA: st_d = SGetB;
      SGetB: st_d = SDiv;
      SDiv: st_d = (dstep_q == '0) ? SMul : SDiv;
      SMul: st_d = SProd;
      SProd: st_d = SAcc;
      SAcc: st_d = (qi_q == 3'd4) ? SOut : SMul;
      SOut: st_d = SIdle;
      default: st_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= SIdle;
      res_valid_q <= 1'b0;
    end else begin
      st_q <= st_d;
      if (st_q == SOut) begin
        res_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    lo_q <= lo_d;
    cnt_q <= cnt_d;
    case (st_q)
      SIdle: begin
        if (job_acc) begin
          job_q <= job_i;
          res_q <= '0;
        end
      end
      SRdB: begin
        // Left point arrives; it is also the answer when the search hits entry 0.
        for (int k = 0; k < 5; k++) pa_q[k] <= rd_data_i[(5-k)*VW-1 -: VW];
      end
      SGetA: begin
        for (int k = 0; k < 5; k++) pb_q[k] <= rd_data_i[(5-k)*VW-1 -: VW];
        dtot_q <= $signed({rd_data_i[4*VW-1], rd_data_i[4*VW-1:3*VW]})
                - $signed({pa_q[1][VW-1], pa_q[1]});
        rem_q <= '0;
        quo_q <= '0;
        dstep_q <= DivCntW'(RW);
        qi_q <= '0;
      end
      SDiv: begin
        if (dstep_q == DivCntW'(RW)) begin
          // Clamp dt into [0, dtot]; a full interval gives the integer bit of the ratio.
          if (dts_w < 0) begin
            rem_q <= '0;
            quo_q <= '0;
          end else if (dts_w >= $signed(dtot_q)) begin
            rem_q <= '0;
            quo_q <= (RW+1)'(1);
          end else begin
            rem_q <= dts_w;
            quo_q <= '0;
          end
          dstep_q <= dstep_q - 1'b1;
        end else if (dstep_q != '0) begin
          if (rem_sh >= dtot_q) begin
            rem_q <= rem_sh - dtot_q;
            quo_q <= {quo_q[RW-1:0], 1'b1};
          end else begin
            rem_q <= rem_sh;
            quo_q <= {quo_q[RW-1:0], 1'b0};
          end
          dstep_q <= dstep_q - 1'b1;
        end else begin
          if (rem_sh >= dtot_q) quo_q <= {quo_q[RW-1:0], 1'b1};
          else quo_q <= {quo_q[RW-1:0], 1'b0};
        end
      end
      SMul: begin
        neg_q <= dx_w < 0;
        mag_q <= (dx_w < 0) ? -dx_w : dx_w;
      end
      SAcc: begin
        res_q.out_time <= job_q.query;
        case (qi_q)
          3'd0: res_q.out_pos <= val_w[VW-1:0];
          3'd2: res_q.out_speed <= val_w[VW-1:0];
          3'd3: res_q.out_accel <= val_w[VW-1:0];
          default: res_q.out_jerk <= val_w[VW-1:0];
        endcase
        qi_q <= (qi_q == 3'd0) ? 3'd2 : qi_q + 1'b1;
      end
      SOut: begin
        res_q.status <= job_q.status;
        res_q.span_time <= job_q.span;
        res_q.point_count <= job_q.count;
        if (job_q.eval && (lo_q == '0 || lo_q >= job_q.count || $signed(dtot_q) <= 0)) begin
          // Whole-point answer: end of search, or a right point whose time is not above the left point's.
          res_q.out_pos <= pa_q[0];
          res_q.out_speed <= pa_q[2];
          res_q.out_accel <= pa_q[3];
          res_q.out_jerk <= pa_q[4];
          res_q.out_time <= (lo_q == '0 || lo_q >= job_q.count) ? pa_q[1] : job_q.query;
          if (lo_q >= job_q.count) begin
            res_q.out_pos <= pb_q[0];
            res_q.out_time <= pb_q[1];
            res_q.out_speed <= pb_q[2];
            res_q.out_accel <= pb_q[3];
            res_q.out_jerk <= pb_q[4];
          end
        end
      end
      default: ;
    endcase
  end

  // Product of magnitude and ratio, with half-ulp rounding, registered before use.
  always_ff @(posedge clk_i) begin
    mulr_q <= mag_q[VW-1:0] * quo_q + (VW+RW+1)'(1 << (RW-1));
  end

  assign out_valid_o = res_valid_q;
  assign out_data_o = res_q;

  `SPTI_ASSERT_IMP(a_busy_stall, clk_i, rst_ni, st_q != SIdle, job_stall_o)
  `SPTI_ASSERT_NXT(a_out_next, clk_i, rst_ni, st_q == SOut, out_valid_o)
  `SPTI_ASSERT_IMP(a_qi_range, clk_i, rst_ni, st_q == SAcc, qi_q != 3'd1)
endmodule

// ===== verif/spti_checker.sv =====
// Checker that predicts interpolator responses and compares them with the block's output.
module spti_checker (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  input  logic           in_stall_i,
  input  spti_pkg::req_t in_data_i,
  input  logic           out_valid_i,
  input  logic           out_stall_i,
  input  spti_pkg::rsp_t out_data_i,
  output int             fail_count_o,
  output int             pending_count_o
);
  logic signed [spti_pkg::ValW-1:0] pos_tab[spti_pkg::Depth];
  logic signed [spti_pkg::ValW-1:0] time_tab[spti_pkg::Depth];
  logic signed [spti_pkg::ValW-1:0] speed_tab[spti_pkg::Depth];
  logic signed [spti_pkg::ValW-1:0] accel_tab[spti_pkg::Depth];
  logic signed [spti_pkg::ValW-1:0] jerk_tab[spti_pkg::Depth];
  int unsigned points_held;
  spti_pkg::rsp_t expected_rsps[$];

  // Linear blend with a Q1.30 ratio, rounding half away from zero.
  function automatic logic signed [spti_pkg::ValW-1:0] blend(longint x0, longint x1,
                                                            longint unsigned r);
    longint dx;
    longint unsigned mag, p;
    dx = x1 - x0;
    mag = (dx < 0) ? longint'(-dx) : dx;
    p = (mag * r + (64'd1 << (spti_pkg::RatW - 1))) >> spti_pkg::RatW;
    return spti_pkg::ValW'((dx < 0) ? x0 - longint'(p) : x0 + longint'(p));
  endfunction

  function automatic spti_pkg::rsp_t predict_rsp(spti_pkg::req_t rq);
    spti_pkg::rsp_t r;
    longint q, t0, t1, span, dts;
    longint unsigned dtot, dt, ratio;
    int unsigned lo, cnt, step, idx, a;
    r = '0;
    case (rq.command)
      spti_pkg::CmdAppend: begin
        if (points_held >= spti_pkg::Depth) begin
          r.status = spti_pkg::StFull;
        end else begin
          pos_tab[points_held] = rq.point_pos;
          time_tab[points_held] = rq.point_time;
          speed_tab[points_held] = rq.point_speed;
          accel_tab[points_held] = rq.point_accel;
          jerk_tab[points_held] = rq.point_jerk;
          points_held++;
        end
      end
      spti_pkg::CmdClear: points_held = 0;
      spti_pkg::CmdEval: begin
        q = rq.point_time;
        if (points_held < 2) begin
          r.status = spti_pkg::StFew;
        end else if (!(time_tab[0] <= q && q <= time_tab[points_held-1])) begin
          r.status = spti_pkg::StSpan;
        end else begin
          lo = 0;
          cnt = points_held;
          while (cnt > 0) begin
            step = cnt / 2;
            idx = lo + step;
            if (time_tab[idx] < q) begin
              lo = idx + 1;
              cnt -= step + 1;
            end else begin
              cnt = step;
            end
          end
          if (lo >= points_held || lo == 0) begin
            idx = (lo == 0) ? 0 : points_held - 1;
            r.out_pos = pos_tab[idx];
            r.out_time = time_tab[idx];
            r.out_speed = speed_tab[idx];
            r.out_accel = accel_tab[idx];
            r.out_jerk = jerk_tab[idx];
          end else begin
            a = lo - 1;
            t0 = time_tab[a];
            t1 = time_tab[lo];
            r.out_time = rq.point_time;
            if (t1 <= t0) begin
              r.out_pos = pos_tab[a];
              r.out_speed = speed_tab[a];
              r.out_accel = accel_tab[a];
              r.out_jerk = jerk_tab[a];
            end else begin
              dtot = t1 - t0;
              dts = q - t0;
              dt = (dts < 0) ? 0 : dts;
              if (dt > dtot) dt = dtot;
              ratio = (dt << spti_pkg::RatW) / dtot;
              r.out_pos = blend(pos_tab[a], pos_tab[lo], ratio);
              r.out_speed = blend(speed_tab[a], speed_tab[lo], ratio);
              r.out_accel = blend(accel_tab[a], accel_tab[lo], ratio);
              r.out_jerk = blend(jerk_tab[a], jerk_tab[lo], ratio);
            end
          end
        end
      end
      default: ;
    endcase
    if (points_held > 0) begin
      span = longint'(time_tab[points_held-1]) - longint'(time_tab[0]);
      if (span > 64'sd2147483647) span = 64'sd2147483647;
      if (span < -64'sd2147483648) span = -64'sd2147483648;
      r.span_time = spti_pkg::ValW'(span);
    end
    r.point_count = spti_pkg::CntW'(points_held);
    return r;
  endfunction

  task automatic check_field(string name, longint exp_v, longint act_v);
    if (exp_v != act_v) begin
      $error("%s mismatch: expected %0d, actual %0d", name, exp_v, act_v);
      fail_count_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    spti_pkg::rsp_t e;
    if (!rst_ni) begin
      points_held = 0;
      fail_count_o = 0;
      expected_rsps.delete();
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (expected_rsps.size() == 0) begin
          $error("response with no request outstanding");
          fail_count_o++;
        end else begin
          e = expected_rsps.pop_front();
          check_field("status", e.status, out_data_i.status);
          check_field("out_pos", e.out_pos, out_data_i.out_pos);
          check_field("out_time", e.out_time, out_data_i.out_time);
          check_field("out_speed", e.out_speed, out_data_i.out_speed);
          check_field("out_accel", e.out_accel, out_data_i.out_accel);
          check_field("out_jerk", e.out_jerk, out_data_i.out_jerk);
          check_field("span_time", e.span_time, out_data_i.span_time);
          check_field("point_count", e.point_count, out_data_i.point_count);
        end
      end
      if (in_valid_i && !in_stall_i) expected_rsps = {expected_rsps, predict_rsp(in_data_i)};
    end
    pending_count_o = expected_rsps.size();
  end
endmodule

// ===== verif/tb.sv =====
// Testbench top for the speed profile time interpolator: stimulus and verdict.
module tb;
  localparam int WatchdogLimit = 20000;

  logic clk_i, rst_ni;
  logic in_valid, in_stall, out_valid, out_stall;
  spti_pkg::req_t in_data;
  spti_pkg::rsp_t out_data;
  int fail_count, pending_count;
  int quiet_cycles = 0;
  bit quiet_mode;
  int sent;
  // Times of the points currently loaded, so queries can target the span.
  int loaded_times[$];

  speed_profile_time_interpolator_unit dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid), .in_stall_o(in_stall), .in_data_i(in_data),
    .out_valid_o(out_valid), .out_stall_i(out_stall), .out_data_o(out_data)
  );

  spti_checker checker_i (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid), .in_stall_i(in_stall), .in_data_i(in_data),
    .out_valid_i(out_valid), .out_stall_i(out_stall), .out_data_i(out_data),
    .fail_count_o(fail_count), .pending_count_o(pending_count)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Watchdog on cycles with no accepted request or response.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= WatchdogLimit) begin
        $display("TEST FAILED");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // Receiver stalls in random bursts.
  initial begin
    out_stall = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (!quiet_mode && $urandom_range(0, 7) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 10)) @(negedge clk_i);
      end
      out_stall <= 1'b0;
    end
  end

  task automatic send(logic [1:0] cmd, int p, int t, int s, int a, int j);
    spti_pkg::req_t rq;
    rq.command = cmd;
    rq.point_pos = p;
    rq.point_time = t;
    rq.point_speed = s;
    rq.point_accel = a;
    rq.point_jerk = j;
    if (!quiet_mode && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(negedge clk_i);
    end
    in_valid <= 1'b1;
    in_data <= rq;
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
    @(negedge clk_i);
    sent++;
    if (cmd == spti_pkg::CmdClear) loaded_times.delete();
    if (cmd == spti_pkg::CmdAppend && loaded_times.size() < spti_pkg::Depth)
      loaded_times = {loaded_times, t};
  endtask

  function automatic int rnd32();
    case ($urandom_range(0, 4))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2: return int'($urandom_range(0, 200)) - 100;
      default: return $urandom;
    endcase
  endfunction

  task automatic append_rand(int t);
    send(spti_pkg::CmdAppend, rnd32(), t, rnd32(), rnd32(), rnd32());
  endtask

  // Clear, then append n points whose times step up by random gaps (the times may wrap).
  task automatic load_sorted(int n, int t_start, int gap_max);
    int t;
    t = t_start;
    send(spti_pkg::CmdClear, $urandom, $urandom, $urandom, $urandom, $urandom);
    for (int k = 0; k < n; k++) begin
      append_rand(t);
      t += $urandom_range(0, gap_max);
    end
  endtask

  task automatic query_rand();
    int t, lo_t, hi_t, sz;
    sz = loaded_times.size();
    case ($urandom_range(0, 9))
      0: t = $urandom;
      1: t = (sz > 0) ? loaded_times[0] : 0;
      2: t = (sz > 0) ? loaded_times[sz-1] : 0;
      3: t = (sz > 0) ? loaded_times[$urandom_range(0, sz-1)] : 0;
      default: begin
        lo_t = (sz > 0) ? loaded_times[0] : 0;
        hi_t = (sz > 0) ? loaded_times[sz-1] : 0;
        if (hi_t > lo_t) t = lo_t + int'($urandom_range(0, hi_t - lo_t));
        else t = lo_t;
      end
    endcase
    send(spti_pkg::CmdEval, $urandom, t, $urandom, $urandom, $urandom);
  endtask

  initial begin
    in_valid = 1'b0;
    in_data = '0;
    quiet_mode = 1'b0;
    sent = 0;
    rst_ni = 1'b0;
    repeat (11) @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: evaluate on an empty and a one-point table, unused command.
    send(spti_pkg::CmdEval, 0, 0, 0, 0, 0);
    send(spti_pkg::CmdAppend, 32'h7fffffff, 32'h80000000, 32'h80000000, 32'h7fffffff, -1);
    send(spti_pkg::CmdEval, 0, 32'h80000000, 0, 0, 0);
    send(2'd3, -1, -1, -1, -1, -1);
    // Span saturation and interpolation across extreme values.
    send(spti_pkg::CmdAppend, 32'h80000000, 32'h7fffffff, 32'h7fffffff, 32'h80000000, 0);
    send(spti_pkg::CmdEval, 0, 0, 0, 0, 0);
    send(spti_pkg::CmdEval, 0, 32'h80000000, 0, 0, 0);
    send(spti_pkg::CmdEval, 0, 32'h7fffffff, 0, 0, 0);
    send(spti_pkg::CmdEval, 0, 32'h80000001, 0, 0, 0);
    // Out of span on both sides and equal neighbor times.
    send(spti_pkg::CmdClear, 0, 0, 0, 0, 0);
    send(spti_pkg::CmdAppend, 10, 100, 20, 30, 40);
    send(spti_pkg::CmdAppend, 50, 200, 60, 70, 80);
    send(spti_pkg::CmdAppend, 90, 200, 11, 12, 13);
    send(spti_pkg::CmdEval, 0, 99, 0, 0, 0);
    send(spti_pkg::CmdEval, 0, 201, 0, 0, 0);
    send(spti_pkg::CmdEval, 0, 150, 0, 0, 0);
    send(spti_pkg::CmdEval, 0, 200, 0, 0, 0);
    send(spti_pkg::CmdEval, 0, 133, 0, 0, 0);
    // Fill the table, then overflow it.
    load_sorted(spti_pkg::Depth, -1000, 50);
    send(spti_pkg::CmdAppend, 1, 2, 3, 4, 5);
    query_rand();
    query_rand();

    while (sent < 1500) begin
      if (sent > 1300) quiet_mode = 1'b1;
      case ($urandom_range(0, 19))
        0: load_sorted($urandom_range(2, spti_pkg::Depth + 2), rnd32(),
                       1 << $urandom_range(0, 24));
        1: send(2'($urandom_range(0, 3)), $urandom, $urandom, $urandom, $urandom, $urandom);
        2: append_rand($urandom);
        3: load_sorted($urandom_range(0, 4), $urandom, 1000);
        default: query_rand();
      endcase
    end
    in_valid <= 1'b0;

    while (pending_count != 0) @(negedge clk_i);
    repeat (100) @(negedge clk_i);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule
